@@ src/rational_arith_unit_assert.svh @@
// Assertion macros shared by the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define RAU_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`endif

@@ src/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Types and codes shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rau_pkg;
   localparam int unsigned WordWidth = 64;
   typedef logic [WordWidth-1:0] word_type;
   typedef logic [1:0] kind_type;
   typedef logic [1:0] status_type;

   localparam kind_type KindReduce = 2'd0;
   localparam kind_type KindAdd    = 2'd1;
   localparam kind_type KindDivide = 2'd2;
   localparam kind_type KindSplit  = 2'd3;

   localparam status_type StatusOk   = 2'd0;
   localparam status_type StatusOvf  = 2'd1;
   localparam status_type StatusZden = 2'd2;
   localparam status_type StatusDivz = 2'd3;

   // Operations of the shared divider unit.
   typedef struct packed {
      logic     start;
      word_type dividend;
      word_type divisor;
   } div_req_type;

   typedef struct packed {
      logic     done;
      word_type quot;
      word_type rem;
   } div_rsp_type;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GA_START, ST_GA_WAIT,     // gcd(an, ad)
      ST_RA1_START, ST_RA1_WAIT,   // an /= g
      ST_RA2_START, ST_RA2_WAIT,   // ad /= g
      ST_GB_START, ST_GB_WAIT,     // gcd(bn, bd)
      ST_RB1_START, ST_RB1_WAIT,
      ST_RB2_START, ST_RB2_WAIT,
      ST_DISPATCH,
      ST_SPL_START, ST_SPL_WAIT,   // an / ad
      ST_ADD_G_START, ST_ADD_G_WAIT,  // gcd(ad, bd)
      ST_ADD_LS_START, ST_ADD_LS_WAIT,
      ST_ADD_RS_START, ST_ADD_RS_WAIT,
      ST_ADD_M1_START, ST_ADD_M1_WAIT,
      ST_ADD_M2_START, ST_ADD_M2_WAIT,
      ST_ADD_SUM,
      ST_ADD_RED_START, ST_ADD_RED_WAIT, // gcd(sum, g)
      ST_ADD_AR_START, ST_ADD_AR_WAIT,   // ad / red
      ST_ADD_M3_START, ST_ADD_M3_WAIT,
      ST_ADD_SR_START, ST_ADD_SR_WAIT,   // sum / red
      ST_DIV_G1_START, ST_DIV_G1_WAIT,
      ST_DIV_G2_START, ST_DIV_G2_WAIT,
      ST_DIV_Q1_START, ST_DIV_Q1_WAIT,   // an / g1
      ST_DIV_Q2_START, ST_DIV_Q2_WAIT,   // bd / g2
      ST_DIV_Q3_START, ST_DIV_Q3_WAIT,   // ad / g2
      ST_DIV_Q4_START, ST_DIV_Q4_WAIT,   // bn / g1
      ST_DIV_M1_START, ST_DIV_M1_WAIT,
      ST_DIV_M2_START, ST_DIV_M2_WAIT,
      ST_FIN_G_START, ST_FIN_G_WAIT,     // final reduce of (rn, rd)
      ST_FIN_R1_START, ST_FIN_R1_WAIT,
      ST_FIN_R2_START, ST_FIN_R2_WAIT,
      ST_OUTPUT
   } state_type;
endpackage
`default_nettype wire

@@ src/rau_stream_if.sv @@
// ----------------------------------------------------------------------------
// rau_stream_if
// Valid/ready channel carrying one word of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none
interface rau_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ src/rau_divider.sv @@
// ----------------------------------------------------------------------------
// rau_divider
// Restoring radix-2 divider, one quotient bit per cycle; also checks a
// 64x64 product for overflow by shift-and-add, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rau_pkg::div_req_type req,
   input  wire logic                 mul_mode,
   output rau_pkg::div_rsp_type      rsp,
   output logic                      mul_ovf
);
   import rau_pkg::*;

   localparam int unsigned CntWidth = $clog2(WordWidth + 1);

   logic                busy_ff, busy_in;
   logic                mode_ff, mode_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   word_type            q_ff, q_in;     // dividend shifting out / multiplier
   word_type            r_ff, r_in;     // remainder / product accumulator
   word_type            d_ff, d_in;     // divisor / multiplicand
   logic                ovf_ff, ovf_in;
   logic                done_ff, done_in;

   logic [WordWidth:0]  trial;
   logic [WordWidth:0]  acc;

   always_comb begin
      busy_in = busy_ff;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      ovf_in  = ovf_ff;
      done_in = 1'b0;
      trial   = '0;
      acc     = '0;
      if (req.start) begin
         busy_in = 1'b1;
         mode_in = mul_mode;
         cnt_in  = CntWidth'(WordWidth);
         q_in    = req.dividend;
         d_in    = req.divisor;
         r_in    = '0;
         ovf_in  = 1'b0;
      end else if (busy_ff) begin
         if (!mode_ff) begin
            trial = {r_ff, q_ff[WordWidth-1]} - {1'b0, d_ff};
            if (!trial[WordWidth]) begin
               r_in = trial[WordWidth-1:0];
               q_in = {q_ff[WordWidth-2:0], 1'b1};
            end else begin
               r_in = {r_ff[WordWidth-2:0], q_ff[WordWidth-1]};
               q_in = {q_ff[WordWidth-2:0], 1'b0};
            end
         end else begin
            // Product MSB-first: acc = 2*acc + bit*d, overflow if bits escape.
            acc = {r_ff, 1'b0};
            if (r_ff[WordWidth-1]) ovf_in = 1'b1;
            acc = {1'b0, acc[WordWidth-1:0]} + (q_ff[WordWidth-1] ? {1'b0, d_ff} : '0);
            if (acc[WordWidth]) ovf_in = 1'b1;
            r_in = acc[WordWidth-1:0];
            q_in = {q_ff[WordWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      d_ff    <= d_in;
      ovf_ff  <= ovf_in;
   end

   // In multiply mode the product sits in rem, quot is not meaningful.
   assign rsp.done = done_ff;
   assign rsp.quot = q_ff;
   assign rsp.rem  = r_ff;
   assign mul_ovf  = ovf_ff;
endmodule
`default_nettype wire

@@ src/rau_gcd.sv @@
// ----------------------------------------------------------------------------
// rau_gcd
// Binary gcd engine: one subtract-or-shift step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rau_gcd (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire rau_pkg::word_type x,
   input  wire rau_pkg::word_type y,
   output logic                   done,
   output rau_pkg::word_type      result
);
   import rau_pkg::*;

   localparam int unsigned ShWidth = $clog2(WordWidth + 1);

   logic               busy_ff, busy_in;
   word_type           u_ff, u_in;
   word_type           v_ff, v_in;
   logic [ShWidth-1:0] sh_ff, sh_in;
   logic               done_ff, done_in;
   word_type           res_ff, res_in;

   always_comb begin
      busy_in = busy_ff;
      u_in    = u_ff;
      v_in    = v_ff;
      sh_in   = sh_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         u_in    = x;
         v_in    = y;
         sh_in   = '0;
      end else if (busy_ff) begin
         if (u_ff == '0) begin
            res_in  = v_ff << sh_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (v_ff == '0) begin
            res_in  = u_ff << sh_ff;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (!u_ff[0] && !v_ff[0]) begin
            u_in  = u_ff >> 1;
            v_in  = v_ff >> 1;
            sh_in = sh_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_in = u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_in = v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_in = (u_ff - v_ff) >> 1;
         end else begin
            v_in = (v_ff - u_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      u_ff   <= u_in;
      v_ff   <= v_in;
      sh_ff  <= sh_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;
endmodule
`default_nettype wire

@@ src/rational_arith_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arith_unit
// Reduce, add, divide and split on unsigned 64-bit fractions.
// ----------------------------------------------------------------------------
// One word is taken at a time and the unit is not ready again until its
// result word has been taken. Every operation runs as a sequence of steps
// on two shared engines: a binary gcd engine (one shift or subtract per
// cycle) and a bit-serial divider that also checks multiplies for
// overflow. Add and divide chain several gcds, divides and multiplies.
// Run time depends on the operand values through the gcd steps. Inputs
// with a zero denominator go straight from the check to the output. The
// status word reports overflow, zero denominator or divide by zero; on
// any error all three value fields read zero, and a zero value is
// returned as 0/1.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rational_arith_unit_assert.svh"
module rational_arith_unit (
   input  wire logic clock,
   input  wire logic reset,
   rau_stream_if.sink   req,
   rau_stream_if.source rsp
);
   import rau_pkg::*;

   state_type   state_ff, state_in;
   kind_type    kind_ff, kind_in;
   word_type    an_ff, an_in, ad_ff, ad_in, bn_ff, bn_in, bd_ff, bd_in;
   word_type    g_ff, g_in;    // working gcd (g, red, g1)
   word_type    h_ff, h_in;    // second gcd (g2) / ls
   word_type    t_ff, t_in;    // rs, p2, ad/red
   word_type    u_ff, u_in;    // p1, sum
   word_type    rn_ff, rn_in, rd_ff, rd_in, wh_ff, wh_in;
   status_type  st_ff, st_in;

   logic        gcd_start;
   word_type    gcd_x, gcd_y, gcd_res;
   logic        gcd_done;
   div_req_type dreq;
   div_rsp_type drsp;
   logic        mul_mode, mul_ovf;
   logic [WordWidth:0] sum_w;

   rau_gcd u_gcd (
      .clock  (clock),
      .reset  (reset),
      .start  (gcd_start),
      .x      (gcd_x),
      .y      (gcd_y),
      .done   (gcd_done),
      .result (gcd_res)
   );

   rau_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (dreq),
      .mul_mode (mul_mode),
      .rsp      (drsp),
      .mul_ovf  (mul_ovf)
   );

   // Next state and datapath registers.
   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      g_in = g_ff; h_in = h_ff; t_in = t_ff; u_in = u_ff;
      rn_in = rn_ff; rd_in = rd_ff; wh_in = wh_ff; st_in = st_ff;
      sum_w = {1'b0, t_ff} + {1'b0, u_ff};
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               kind_in = req.payload.kind;
               an_in = req.payload.a_num; ad_in = req.payload.a_den;
               bn_in = req.payload.b_num; bd_in = req.payload.b_den;
               rn_in = '0; rd_in = '0; wh_in = '0; st_in = StatusOk;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (ad_ff == '0 ||
                ((kind_ff == KindAdd || kind_ff == KindDivide) && bd_ff == '0)) begin
               st_in = StatusZden;
               state_in = ST_OUTPUT;
            end else begin
               state_in = ST_GA_START;
            end
         end
         ST_GA_START:  state_in = ST_GA_WAIT;
         ST_GA_WAIT:   if (gcd_done) begin g_in = gcd_res; state_in = ST_RA1_START; end
         ST_RA1_START: state_in = ST_RA1_WAIT;
         ST_RA1_WAIT:  if (drsp.done) begin an_in = drsp.quot; state_in = ST_RA2_START; end
         ST_RA2_START: state_in = ST_RA2_WAIT;
         ST_RA2_WAIT: begin
            if (drsp.done) begin
               ad_in = drsp.quot;
               state_in = (kind_ff == KindAdd || kind_ff == KindDivide) ?
                          ST_GB_START : ST_DISPATCH;
            end
         end
         ST_GB_START:  state_in = ST_GB_WAIT;
         ST_GB_WAIT:   if (gcd_done) begin g_in = gcd_res; state_in = ST_RB1_START; end
         ST_RB1_START: state_in = ST_RB1_WAIT;
         ST_RB1_WAIT:  if (drsp.done) begin bn_in = drsp.quot; state_in = ST_RB2_START; end
         ST_RB2_START: state_in = ST_RB2_WAIT;
         ST_RB2_WAIT:  if (drsp.done) begin bd_in = drsp.quot; state_in = ST_DISPATCH; end
         ST_DISPATCH: begin
            case (kind_ff)
               KindReduce: begin
                  rn_in = an_ff; rd_in = ad_ff; state_in = ST_OUTPUT;
               end
               KindSplit:  state_in = ST_SPL_START;
               KindAdd:    state_in = ST_ADD_G_START;
               default: begin
                  if (bn_ff == '0) begin
                     st_in = StatusDivz; state_in = ST_OUTPUT;
                  end else begin
                     state_in = ST_DIV_G1_START;
                  end
               end
            endcase
         end
         ST_SPL_START: state_in = ST_SPL_WAIT;
         ST_SPL_WAIT: begin
            if (drsp.done) begin
               wh_in = drsp.quot; rn_in = drsp.rem; rd_in = ad_ff;
               state_in = ST_FIN_G_START;
            end
         end
         // Add: g = gcd(ad,bd); ls = bd/g; rs = ad/g.
         ST_ADD_G_START:  state_in = ST_ADD_G_WAIT;
         ST_ADD_G_WAIT:   if (gcd_done) begin g_in = gcd_res; state_in = ST_ADD_LS_START; end
         ST_ADD_LS_START: state_in = ST_ADD_LS_WAIT;
         ST_ADD_LS_WAIT:  if (drsp.done) begin h_in = drsp.quot; state_in = ST_ADD_RS_START; end
         ST_ADD_RS_START: state_in = ST_ADD_RS_WAIT;
         ST_ADD_RS_WAIT:  if (drsp.done) begin t_in = drsp.quot; state_in = ST_ADD_M1_START; end
         ST_ADD_M1_START: state_in = ST_ADD_M1_WAIT;
         ST_ADD_M1_WAIT: begin
            if (drsp.done) begin
               if (mul_ovf) begin
                  st_in = StatusOvf; state_in = ST_OUTPUT;
               end else begin
                  u_in = drsp.rem;        // p1 parked in u while p2 is made
                  state_in = ST_ADD_M2_START;
               end
            end
         end
         ST_ADD_M2_START: state_in = ST_ADD_M2_WAIT;
         ST_ADD_M2_WAIT: begin
            if (drsp.done) begin
               if (mul_ovf) begin
                  st_in = StatusOvf; state_in = ST_OUTPUT;
               end else begin
                  t_in = drsp.rem;
                  state_in = ST_ADD_SUM;
               end
            end
         end
         ST_ADD_SUM: begin
            if (sum_w[WordWidth]) begin
               st_in = StatusOvf; state_in = ST_OUTPUT;
            end else begin
               u_in = sum_w[WordWidth-1:0];
               state_in = ST_ADD_RED_START;
            end
         end
         ST_ADD_RED_START: state_in = ST_ADD_RED_WAIT;
         ST_ADD_RED_WAIT:  if (gcd_done) begin g_in = gcd_res; state_in = ST_ADD_AR_START; end
         ST_ADD_AR_START:  state_in = ST_ADD_AR_WAIT;
         ST_ADD_AR_WAIT:   if (drsp.done) begin t_in = drsp.quot; state_in = ST_ADD_M3_START; end
         ST_ADD_M3_START:  state_in = ST_ADD_M3_WAIT;
         ST_ADD_M3_WAIT: begin
            if (drsp.done) begin
               if (mul_ovf) begin
                  st_in = StatusOvf; state_in = ST_OUTPUT;
               end else begin
                  rd_in = drsp.rem; state_in = ST_ADD_SR_START;
               end
            end
         end
         ST_ADD_SR_START: state_in = ST_ADD_SR_WAIT;
         ST_ADD_SR_WAIT:  if (drsp.done) begin rn_in = drsp.quot; state_in = ST_FIN_G_START; end
         // Divide: g1 = gcd(an,bn), g2 = gcd(bd,ad), n = an/g1*bd/g2, d = ad/g2*bn/g1.
         ST_DIV_G1_START: state_in = ST_DIV_G1_WAIT;
         ST_DIV_G1_WAIT:  if (gcd_done) begin g_in = gcd_res; state_in = ST_DIV_G2_START; end
         ST_DIV_G2_START: state_in = ST_DIV_G2_WAIT;
         ST_DIV_G2_WAIT:  if (gcd_done) begin h_in = gcd_res; state_in = ST_DIV_Q1_START; end
         ST_DIV_Q1_START: state_in = ST_DIV_Q1_WAIT;
         ST_DIV_Q1_WAIT:  if (drsp.done) begin an_in = drsp.quot; state_in = ST_DIV_Q2_START; end
         ST_DIV_Q2_START: state_in = ST_DIV_Q2_WAIT;
         ST_DIV_Q2_WAIT:  if (drsp.done) begin bd_in = drsp.quot; state_in = ST_DIV_Q3_START; end
         ST_DIV_Q3_START: state_in = ST_DIV_Q3_WAIT;
         ST_DIV_Q3_WAIT:  if (drsp.done) begin ad_in = drsp.quot; state_in = ST_DIV_Q4_START; end
         ST_DIV_Q4_START: state_in = ST_DIV_Q4_WAIT;
         ST_DIV_Q4_WAIT:  if (drsp.done) begin bn_in = drsp.quot; state_in = ST_DIV_M1_START; end
         ST_DIV_M1_START: state_in = ST_DIV_M1_WAIT;
         ST_DIV_M1_WAIT: begin
            if (drsp.done) begin
               if (mul_ovf) begin
                  st_in = StatusOvf; state_in = ST_OUTPUT;
               end else begin
                  rn_in = drsp.rem; state_in = ST_DIV_M2_START;
               end
            end
         end
         ST_DIV_M2_START: state_in = ST_DIV_M2_WAIT;
         ST_DIV_M2_WAIT: begin
            if (drsp.done) begin
               if (mul_ovf) begin
                  st_in = StatusOvf; state_in = ST_OUTPUT;
               end else begin
                  rd_in = drsp.rem; state_in = ST_FIN_G_START;
               end
            end
         end
         // Final reduce of rn/rd; rd is never zero here.
         ST_FIN_G_START:  state_in = ST_FIN_G_WAIT;
         ST_FIN_G_WAIT:   if (gcd_done) begin g_in = gcd_res; state_in = ST_FIN_R1_START; end
         ST_FIN_R1_START: state_in = ST_FIN_R1_WAIT;
         ST_FIN_R1_WAIT:  if (drsp.done) begin rn_in = drsp.quot; state_in = ST_FIN_R2_START; end
         ST_FIN_R2_START: state_in = ST_FIN_R2_WAIT;
         ST_FIN_R2_WAIT:  if (drsp.done) begin rd_in = drsp.quot; state_in = ST_OUTPUT; end
         ST_OUTPUT: begin
            if (st_ff != StatusOk) begin
               rn_in = '0; rd_in = '0; wh_in = '0;
            end
            // Leave only once the result word has actually been taken.
            if (rsp.valid && rsp.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Operand selection and start pulses for the shared engines.
   always_comb begin
      gcd_start = 1'b0;
      gcd_x = an_ff;
      gcd_y = ad_ff;
      dreq = '0;
      mul_mode = 1'b0;
      case (state_ff)
         ST_GA_START:      begin gcd_start = 1'b1; gcd_x = an_ff; gcd_y = ad_ff; end
         ST_GB_START:      begin gcd_start = 1'b1; gcd_x = bn_ff; gcd_y = bd_ff; end
         ST_ADD_G_START:   begin gcd_start = 1'b1; gcd_x = ad_ff; gcd_y = bd_ff; end
         ST_ADD_RED_START: begin gcd_start = 1'b1; gcd_x = u_ff;  gcd_y = g_ff;  end
         ST_DIV_G1_START:  begin gcd_start = 1'b1; gcd_x = an_ff; gcd_y = bn_ff; end
         ST_DIV_G2_START:  begin gcd_start = 1'b1; gcd_x = bd_ff; gcd_y = ad_ff; end
         ST_FIN_G_START:   begin gcd_start = 1'b1; gcd_x = rn_ff; gcd_y = rd_ff; end
         ST_RA1_START:     dreq = '{1'b1, an_ff, g_ff};
         ST_RA2_START:     dreq = '{1'b1, ad_ff, g_ff};
         ST_RB1_START:     dreq = '{1'b1, bn_ff, g_ff};
         ST_RB2_START:     dreq = '{1'b1, bd_ff, g_ff};
         ST_SPL_START:     dreq = '{1'b1, an_ff, ad_ff};
         ST_ADD_LS_START:  dreq = '{1'b1, bd_ff, g_ff};
         ST_ADD_RS_START:  dreq = '{1'b1, ad_ff, g_ff};
         ST_ADD_M1_START:  begin dreq = '{1'b1, an_ff, h_ff}; mul_mode = 1'b1; end
         ST_ADD_M2_START:  begin dreq = '{1'b1, bn_ff, t_ff}; mul_mode = 1'b1; end
         ST_ADD_AR_START:  dreq = '{1'b1, ad_ff, g_ff};
         ST_ADD_M3_START:  begin dreq = '{1'b1, t_ff, h_ff}; mul_mode = 1'b1; end
         ST_ADD_SR_START:  dreq = '{1'b1, u_ff, g_ff};
         ST_DIV_Q1_START:  dreq = '{1'b1, an_ff, g_ff};
         ST_DIV_Q2_START:  dreq = '{1'b1, bd_ff, h_ff};
         ST_DIV_Q3_START:  dreq = '{1'b1, ad_ff, h_ff};
         ST_DIV_Q4_START:  dreq = '{1'b1, bn_ff, g_ff};
         ST_DIV_M1_START:  begin dreq = '{1'b1, an_ff, bd_ff}; mul_mode = 1'b1; end
         ST_DIV_M2_START:  begin dreq = '{1'b1, ad_ff, bn_ff}; mul_mode = 1'b1; end
         ST_FIN_R1_START:  dreq = '{1'b1, rn_ff, g_ff};
         ST_FIN_R2_START:  dreq = '{1'b1, rd_ff, g_ff};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      g_ff <= g_in; h_ff <= h_in; t_ff <= t_in; u_ff <= u_in;
      rn_ff <= rn_in; rd_ff <= rd_in; wh_ff <= wh_in; st_ff <= st_in;
   end

   // Error results are cleared on the first cycle of the output state, so
   // the result word is raised in the cycle after entering it.
   logic out_ok_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ok_ff <= 1'b0;
      end else begin
         out_ok_ff <= (state_ff == ST_OUTPUT) && !(out_ok_ff && rsp.ready);
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUTPUT) && out_ok_ff;
   assign rsp.payload.res_num    = rn_ff;
   assign rsp.payload.res_den    = rd_ff;
   assign rsp.payload.whole_part = wh_ff;
   assign rsp.payload.status     = st_ff;

   `RAU_ASSERT_IMP(a_err_zero, clock, reset,
      rsp.valid && rsp.payload.status != StatusOk,
      rsp.payload.res_num == '0 && rsp.payload.res_den == '0)
   `RAU_ASSERT_IMP(a_ok_den, clock, reset,
      rsp.valid && rsp.payload.status == StatusOk, rsp.payload.res_den != '0)
   `RAU_ASSERT_NEXT(a_accept_leaves_idle, clock, reset,
      req.valid && req.ready, !req.ready)
   `RAU_ASSERT_IMP(a_one_side, clock, reset, req.ready, !rsp.valid)
endmodule
`default_nettype wire
